// ----- hw/rtl/mandelbrot_escape_time_top_assert.svh -----
// Assertion macros shared by the mandelbrot escape-time RTL.
// No dependencies.
`ifndef MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH
// implication checked every cycle outside reset
`define MET_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hw/rtl/met_pkg.sv -----
// Package for the mandelbrot escape-time block: types, register indexes, constants, a 32-bit saturation function.
// No dependencies.
`timescale 1ns / 1ps
package met_pkg;
    localparam int FRAC_BITS = 28;
    localparam int ITER_BITS = 16;
    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS = 13;
    localparam int DATA_BITS = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_REAL_MIN = 3'd0,
        REG_REAL_MAX = 3'd1,
        REG_IMAG_MIN = 3'd2,
        REG_IMAG_MAX = 3'd3,
        REG_IMAGE_WIDTH = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5,
        REG_MAX_ITERATIONS = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_column;
        logic [COORD_BITS-1:0] pixel_row;
    } t_in_word;

    typedef struct packed {
        logic [ITER_BITS-1:0] iteration_count;
        logic inside_set;
    } t_out_word;

    // point handed from mapper to iterator
    typedef struct packed {
        logic signed [DATA_BITS-1:0] c_re;
        logic signed [DATA_BITS-1:0] c_im;
    } t_point;

    function automatic logic signed [DATA_BITS-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else return v[DATA_BITS-1:0];
    endfunction
endpackage

// ----- hw/rtl/met_map.sv -----
// Front part: maps a pixel onto the complex plane with a serial divider.
// Depends on met_pkg.
`timescale 1ns / 1ps
module met_map (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  met_pkg::t_in_word i_word,
    input  logic signed [31:0] i_real_min,
    input  logic signed [31:0] i_real_max,
    input  logic signed [31:0] i_imag_min,
    input  logic signed [31:0] i_imag_max,
    input  logic [12:0] i_image_width,
    input  logic [12:0] i_image_height,
    output logic o_valid,
    input  logic i_stall,
    output met_pkg::t_point o_point
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SUM, S_OUT} t_state;
    t_state r_state;
    logic r_axis;          // 0 real, 1 imaginary
    logic [11:0] r_col, r_row;
    logic [44:0] r_num, r_quo;
    logic [45:0] r_rem;
    logic [12:0] r_div;
    logic [5:0] r_cnt;
    logic r_neg;
    logic signed [31:0] r_c_re, r_c_im;

    logic signed [44:0] w_prod;     // coord * span
    logic signed [32:0] w_span;
    logic [12:0] w_size;
    logic signed [31:0] w_lo;
    logic [45:0] w_rem_sh;
    logic [45:0] w_rem_sub;
    logic signed [65:0] w_sum;

    assign w_lo   = r_axis ? i_imag_min : i_real_min;
    assign w_span = r_axis ? (33'(i_imag_max) - 33'(i_imag_min))
                           : (33'(i_real_max) - 33'(i_real_min));
    assign w_size = r_axis ? i_image_height : i_image_width;
    assign w_prod = 45'(signed'({1'b0, r_axis ? r_row : r_col})) * 45'(w_span);
    assign w_rem_sh  = {r_rem[44:0], r_num[44]};
    assign w_rem_sub = w_rem_sh - 46'(r_div);
    assign w_sum = 66'(w_lo) + (r_neg ? -66'(signed'({1'b0, r_quo}))
                                      : 66'(signed'({1'b0, r_quo})));

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_point = '{c_re: r_c_re, c_im: r_c_im};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_col <= i_word.pixel_column;
                    r_row <= i_word.pixel_row;
                    r_axis <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_neg <= w_prod[44];
                    r_num <= w_prod[44] ? 45'(-w_prod) : 45'(w_prod);
                    r_div <= (w_size >= 13'd2) ? w_size - 13'd1 : 13'd1;
                    r_rem <= '0;
                    r_cnt <= 6'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (w_rem_sh >= 46'(r_div)) begin
                        r_rem <= w_rem_sub;
                        r_quo <= {r_quo[43:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_quo <= {r_quo[43:0], 1'b0};
                    end
                    r_num <= {r_num[43:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd44) r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_axis) begin
                        r_c_im <= met_pkg::sat32(w_sum);
                        r_state <= S_OUT;
                    end else begin
                        r_c_re <= met_pkg::sat32(w_sum);
                        r_axis <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/met_queue.sv -----
// Short point queue between mapper and iterator.
// Depends on met_pkg.
`timescale 1ns / 1ps
module met_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  met_pkg::t_point i_point,
    output logic o_valid,
    input  logic i_stall,
    output met_pkg::t_point o_point
);
    met_pkg::t_point r_mem [met_pkg::QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_stall = (r_cnt == 2'(met_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_point = r_mem[r_rp];
    assign w_push = i_valid && !o_stall;
    assign w_pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_point;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    `include "mandelbrot_escape_time_top_assert.svh"
    `MET_ASSERT_IMPL(a_q_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2, "queue overfilled")
    `MET_ASSERT_NEXT(a_q_push, i_clk, i_rst_n, w_push && !w_pop, r_cnt != 2'd0, "push lost")
    `MET_ASSERT_NEXT(a_q_pop, i_clk, i_rst_n, w_pop && !w_push, r_cnt != 2'd2, "pop lost")
endmodule

// ----- hw/rtl/met_iter.sv -----
// Back part: escape-time iteration, each complex step a multiply state then an update state.
// Depends on met_pkg.
`timescale 1ns / 1ps
module met_iter (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  met_pkg::t_point i_point,
    input  logic [15:0] i_max_iterations,
    output logic o_valid,
    input  logic i_stall,
    output met_pkg::t_out_word o_word
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_UPD, S_OUT} t_state;
    t_state r_state;
    logic signed [31:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [63:0] r_rr, r_ii, r_ri;
    logic [15:0] r_cnt;
    logic r_inside;

    logic [64:0] w_mag;
    logic signed [64:0] w_diff;
    logic signed [65:0] w_nr, w_ni;

    assign w_mag  = 65'(unsigned'(r_rr)) + 65'(unsigned'(r_ii));
    assign w_diff = 65'(r_rr) - 65'(r_ii);
    // arithmetic shift floors
    assign w_ni = 66'(r_ri >>> (met_pkg::FRAC_BITS - 1)) + 66'(r_ci);
    assign w_nr = 66'(w_diff >>> met_pkg::FRAC_BITS) + 66'(r_cr);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_word = '{iteration_count: r_cnt, inside_set: r_inside};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cr <= i_point.c_re;
                    r_ci <= i_point.c_im;
                    r_zr <= i_point.c_re;
                    r_zi <= i_point.c_im;
                    r_cnt <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_rr <= r_zr * r_zr;
                    r_ii <= r_zi * r_zi;
                    r_ri <= r_zr * r_zi;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_cnt >= i_max_iterations) begin
                        r_inside <= 1'b1;
                        r_state <= S_OUT;
                    end else if (w_mag >= (65'd1 << (2 * met_pkg::FRAC_BITS + 2))) begin
                        r_inside <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_zr <= met_pkg::sat32(w_nr);
                        r_zi <= met_pkg::sat32(w_ni);
                        r_cnt <= r_cnt + 16'd1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "mandelbrot_escape_time_top_assert.svh"
    `MET_ASSERT_IMPL(a_it_cap, i_clk, i_rst_n, r_state == S_MUL, r_cnt <= i_max_iterations, "count past cap")
    `MET_ASSERT_NEXT(a_it_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(r_cnt), "result dropped")
endmodule

// ----- hw/rtl/mandelbrot_escape_time_top.sv -----
// Coordinate mapping uses two 45-step serial divides, one per axis; the iterator then
// runs one multiply state and one update state per iteration, up to max_iterations.
// Mapper and iterator overlap through the queue; each takes a new pixel only when idle.
// Reset: synchronous active-low i_rst_n restores register defaults and empties the queue.
// Depends on met_pkg, met_map, met_queue, met_iter.
`timescale 1ns / 1ps
module mandelbrot_escape_time_top (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  met_pkg::t_in_word i_word,
    output logic o_valid,
    input  logic i_stall,
    output met_pkg::t_out_word o_word,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    // configuration registers
    logic signed [31:0] r_real_min, r_real_max, r_imag_min, r_imag_max;
    logic [12:0] r_image_width, r_image_height;
    logic [15:0] r_max_iterations;
    logic w_mv, w_ms, w_qv, w_qs;
    met_pkg::t_point w_mp, w_qp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_min <= -32'sd536870912;
            r_real_max <= 32'sd268435456;
            r_imag_min <= -32'sd402653184;
            r_imag_max <= 32'sd402653184;
            r_image_width <= 13'd1024;
            r_image_height <= 13'd1024;
            r_max_iterations <= 16'd256;
        end else if (i_cfg_valid) begin
            unique case (met_pkg::t_reg_idx'(i_cfg_index))
                met_pkg::REG_REAL_MIN: r_real_min <= i_cfg_data;
                met_pkg::REG_REAL_MAX: r_real_max <= i_cfg_data;
                met_pkg::REG_IMAG_MIN: r_imag_min <= i_cfg_data;
                met_pkg::REG_IMAG_MAX: r_imag_max <= i_cfg_data;
                met_pkg::REG_IMAGE_WIDTH: r_image_width <= i_cfg_data[12:0];
                met_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[12:0];
                met_pkg::REG_MAX_ITERATIONS: r_max_iterations <= i_cfg_data[15:0];
                default: ;  // unknown index ignored
            endcase
        end
    end

    // front: coordinate mapping
    met_map u_map (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_word,
        .i_real_min(r_real_min), .i_real_max(r_real_max),
        .i_imag_min(r_imag_min), .i_imag_max(r_imag_max),
        .i_image_width(r_image_width), .i_image_height(r_image_height),
        .o_valid(w_mv), .i_stall(w_ms), .o_point(w_mp)
    );

    // decoupling queue
    met_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_mv), .o_stall(w_ms), .i_point(w_mp),
        .o_valid(w_qv), .i_stall(w_qs), .o_point(w_qp)
    );

    // back: iteration
    met_iter u_iter (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_stall(w_qs), .i_point(w_qp),
        .i_max_iterations(r_max_iterations),
        .o_valid, .i_stall, .o_word
    );
endmodule

// ----- tb/tb_mandelbrot_escape_time_top.sv -----
// Self-checking testbench for mandelbrot_escape_time_top: directed corner pixels and
// register settings, randomized windows and caps, and a long receiver hold-off.
// Depends on met_pkg and the mandelbrot_escape_time_top RTL.
`timescale 1ns / 1ps
module tb_mandelbrot_escape_time_top;
    localparam int CLK_HALF = 6;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int LONG_HOLD = 3000;
    localparam int DRAIN_CYCLES = 300;
    localparam int IDLE_PCT = 19;
    localparam logic [met_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam longint unsigned ESCAPE_RADIUS_SQ = 64'd1 << (2 * met_pkg::FRAC_BITS + 2);
    localparam int ONE_Q = 1 << met_pkg::FRAC_BITS;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    met_pkg::t_in_word i_word;
    logic o_valid;
    logic i_stall;
    met_pkg::t_out_word o_word;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    mandelbrot_escape_time_top i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_word(i_word),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_word(o_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // shadow copy of the register file
    logic signed [31:0] win_real_min, win_real_max, win_imag_min, win_imag_max;
    logic [met_pkg::SIZE_BITS-1:0] img_width, img_height;
    logic [met_pkg::ITER_BITS-1:0] iter_cap;

    met_pkg::t_out_word pending_counts[$];
    int fail_cnt = 0;
    int quiet_cycles = 0;
    bit send_idle = 1;   // sender gaps enabled
    bit recv_idle = 1;   // receiver stalls enabled
    bit hold_req = 0;    // one-shot request for a long receiver hold-off
    int hold_left = 0;

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // linear pixel-to-plane mapping, quotient truncated toward zero
    function automatic logic signed [31:0] plane_coord(
            input logic [met_pkg::COORD_BITS-1:0] pix,
            input logic signed [31:0] lo, input logic signed [31:0] hi,
            input logic [met_pkg::SIZE_BITS-1:0] size);
        longint dv, span, off;
        dv = (size >= 2) ? longint'(size) - 1 : 64'sd1;
        span = longint'(hi) - longint'(lo);
        off = (longint'(pix) * span) / dv;
        return clamp32(longint'(lo) + off);
    endfunction

    function automatic met_pkg::t_out_word escape_time(input met_pkg::t_in_word w);
        logic signed [31:0] cr, ci, zr, zi;
        longint unsigned ar, ai;
        longint sq_diff, cross_prod;
        int unsigned count;
        met_pkg::t_out_word r;
        cr = plane_coord(w.pixel_column, win_real_min, win_real_max, img_width);
        ci = plane_coord(w.pixel_row, win_imag_min, win_imag_max, img_height);
        zr = cr;
        zi = ci;
        count = 0;
        while (1) begin
            ar = (zr < 0) ? longint'(-longint'(zr)) : longint'(zr);
            ai = (zi < 0) ? longint'(-longint'(zi)) : longint'(zi);
            if (ar * ar + ai * ai >= ESCAPE_RADIUS_SQ || count >= iter_cap) break;
            count++;
            sq_diff = longint'(zr) * longint'(zr) - longint'(zi) * longint'(zi);
            cross_prod = longint'(zr) * longint'(zi);
            zr = clamp32((sq_diff >>> met_pkg::FRAC_BITS) + longint'(cr));
            zi = clamp32((cross_prod >>> (met_pkg::FRAC_BITS - 1)) + longint'(ci));
        end
        r.iteration_count = count[met_pkg::ITER_BITS-1:0];
        r.inside_set = (count >= iter_cap);
        return r;
    endfunction

    // Sender: valid stays high across back-to-back words, lowered only for a gap or at the end of a burst.
    task automatic send_pixel(input int col, input int row);
        while (send_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word.pixel_column <= col[met_pkg::COORD_BITS-1:0];
        i_word.pixel_row <= row[met_pkg::COORD_BITS-1:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        begin
            met_pkg::t_in_word w;
            w.pixel_column = col[met_pkg::COORD_BITS-1:0];
            w.pixel_row = row[met_pkg::COORD_BITS-1:0];
            pending_counts.insert(pending_counts.size(), escape_time(w));
        end
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
    endtask

    // Register write; the block is idle whenever the caller gets here.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            met_pkg::REG_REAL_MIN: win_real_min = data;
            met_pkg::REG_REAL_MAX: win_real_max = data;
            met_pkg::REG_IMAG_MIN: win_imag_min = data;
            met_pkg::REG_IMAG_MAX: win_imag_max = data;
            met_pkg::REG_IMAGE_WIDTH: img_width = data[met_pkg::SIZE_BITS-1:0];
            met_pkg::REG_IMAGE_HEIGHT: img_height = data[met_pkg::SIZE_BITS-1:0];
            met_pkg::REG_MAX_ITERATIONS: iter_cap = data[met_pkg::ITER_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_window(input int rmin, input int rmax, input int imin, input int imax);
        write_reg(met_pkg::REG_REAL_MIN, rmin);
        write_reg(met_pkg::REG_REAL_MAX, rmax);
        write_reg(met_pkg::REG_IMAG_MIN, imin);
        write_reg(met_pkg::REG_IMAG_MAX, imax);
    endtask

    task automatic set_frame(input int w, input int h, input int cap);
        write_reg(met_pkg::REG_IMAGE_WIDTH, w);
        write_reg(met_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(met_pkg::REG_MAX_ITERATIONS, cap);
    endtask

    // reset view: corners, edges and a few interior pixels
    task automatic test_reset_view();
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        send_pixel(682, 511);    // near c = 0, stays inside
        send_pixel(1023, 1023);
        send_pixel(341, 600);
        end_burst();
    endtask

    // degenerate sizes, reversed and extreme bounds, zero and unit caps
    task automatic test_corner_settings();
        set_frame(0, 1, 1);
        set_window(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(1, 1);
        end_burst();
        set_frame(8191, 2, 0);   // zero cap: count 0, inside
        set_window(0, ONE_Q, 0, ONE_Q / 2);
        send_pixel(0, 0);
        send_pixel(4095, 1);
        end_burst();
        set_frame(2, 2, 65535 & 16'h0007);
        set_window(3 * ONE_Q, -3 * ONE_Q, ONE_Q, -ONE_Q);  // reversed
        send_pixel(0, 0);        // escapes at start
        send_pixel(1, 1);
        send_pixel(4095, 4095);  // extrapolated far out, saturates
        end_burst();
        write_reg(REG_UNUSED, 32'hffffffff);  // ignored
        set_frame(4096, 4096, 1);
        send_pixel(2048, 2048);
        send_pixel(4095, 0);
        end_burst();
    endtask

    // largest cap: one pixel at c = 0 runs the full count, then three pixels on a wider window
    task automatic test_full_cap();
        set_window(0, 0, 0, 0);
        set_frame(16, 16, 65535);
        send_pixel(3, 3);
        end_burst();
        set_window(-2 * ONE_Q, 2 * ONE_Q, -2 * ONE_Q, 2 * ONE_Q);
        send_pixel(0, 0);
        send_pixel(15, 2);
        send_pixel(1, 14);
        end_burst();
    endtask

    task automatic random_settings();
        int span;
        if ($urandom_range(9) == 0) begin
            set_window($urandom, $urandom, $urandom, $urandom);
        end else begin
            span = 3 * ONE_Q;
            set_window(int'($urandom_range(span)) - 5 * (ONE_Q / 2),
                       int'($urandom_range(span)) - ONE_Q,
                       int'($urandom_range(span)) - 3 * (ONE_Q / 2),
                       int'($urandom_range(span)) - 3 * (ONE_Q / 2));
        end
        if ($urandom_range(4) == 0)
            set_frame($urandom_range(8191), $urandom_range(8191), $urandom_range(200));
        else
            set_frame($urandom_range(4096, 2), $urandom_range(64, 2), $urandom_range(48, 1));
    endtask

    task automatic test_random_frames();
        for (int p = 0; p < 8; p++) begin
            random_settings();
            send_idle = (p != 3);   // one phase without any idling
            recv_idle = (p != 3);
            for (int n = 0; n < 90; n++) begin
                if ($urandom_range(3) == 0)
                    send_pixel($urandom_range(4095), $urandom_range(4095));
                else
                    send_pixel($urandom_range(img_width > 1 ? img_width - 1 : 0),
                               $urandom_range(img_height > 1 ? img_height - 1 : 0));
            end
            end_burst();
        end
        send_idle = 1;
        recv_idle = 1;
    endtask

    // receiver holds off while the sender keeps pushing, so the input backs up
    task automatic test_backpressure();
        set_window(-2 * ONE_Q, ONE_Q, -ONE_Q, ONE_Q);
        set_frame(32, 32, 12);
        send_idle = 0;
        hold_req = 1;
        for (int n = 0; n < 30; n++) send_pixel($urandom_range(31), $urandom_range(31));
        end_burst();
        send_idle = 1;
    endtask

    // Result checker and receiver stall driver; samples on the rising edge.
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            if (pending_counts.size() == 0) begin
                $error("unexpected result word: count %0d inside %0d",
                       o_word.iteration_count, o_word.inside_set);
                fail_cnt++;
            end else begin
                met_pkg::t_out_word want;
                want = pending_counts.pop_front();
                if (o_word.iteration_count !== want.iteration_count) begin
                    $error("iteration_count: expected %0d, got %0d",
                           want.iteration_count, o_word.iteration_count);
                    fail_cnt++;
                end
                if (o_word.inside_set !== want.inside_set) begin
                    $error("inside_set: expected %0d, got %0d",
                           want.inside_set, o_word.inside_set);
                    fail_cnt++;
                end
            end
        end
        if (hold_req) begin
            hold_req = 0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= recv_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("mandelbrot_escape_time_top regression: fail");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_word = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        win_real_min = -536870912;
        win_real_max = 268435456;
        win_imag_min = -402653184;
        win_imag_max = 402653184;
        img_width = 1024;
        img_height = 1024;
        iter_cap = 256;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_view();
        test_corner_settings();
        test_full_cap();
        test_backpressure();
        test_random_frames();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending_counts.size() == 0)
            $display("mandelbrot_escape_time_top regression: pass");
        else
            $display("mandelbrot_escape_time_top regression: fail");
        $finish;
    end
endmodule
